### rtl/hrtm_pkg.sv
// ----------------------------------------------------------------------------
// hrtm_pkg
// Shared constants, types and table builders for the half-float RGBA tone
// mapper: Q30 fixed-point constants, pipeline latency and ROM contents.
// ----------------------------------------------------------------------------
package hrtm_pkg;

    // table geometry: 2^TAB_BITS segments, linear interpolation in between
    localparam int TAB_BITS = 10;
    localparam int TAB_N    = 1 << TAB_BITS;
    localparam int FRAC_SH  = 30 - TAB_BITS;

    // interpolating lookup: ROM read, slope multiply, add
    localparam int LUT_LAT  = 3;
    // colour path: five lookups plus sixteen arithmetic stages
    localparam int PIPE_LAT = 16 + 5 * LUT_LAT;

    localparam logic [33:0] Q30_ONE   = 34'd1 << 30;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [27:0] KNEE_Q30  = 28'd198506946;
    localparam logic [28:0] EXPO_Q30  = 29'd488015659;
    localparam logic [22:0] SCALE_Q16 = 23'd5548278;

    localparam logic signed [39:0] OFFSET_Q30 = 40'sd2656362111;
    localparam logic signed [39:0] GAIN_LIM   = 40'sd21474836480;
    localparam logic signed [39:0] SAT_LOG    = 40'sd5368709120;
    localparam logic signed [39:0] FLOOR_LOG  = -40'sd17179869184;

    // ln2 / knee as a 2^-40 reciprocal, split for two narrower multipliers
    localparam int          RECIP_SH    = 40;
    localparam int          RECIP_SPLIT = 21;
    localparam logic [41:0] KNEE_RECIP  =
        42'((128'(LN2_Q30) << RECIP_SH) / 128'(KNEE_Q30));
    localparam logic [20:0] RECIP_HI    = 21'(KNEE_RECIP >> RECIP_SPLIT);
    localparam logic [20:0] RECIP_LO    = KNEE_RECIP[20:0];

    typedef enum logic [1:0] {
        KIND_CALC,
        KIND_ZERO,
        KIND_FULL
    } t_kind;

    typedef enum logic {
        TAB_LOG,
        TAB_EXP
    } t_tab;

    // log2(1 + i/N) in Q30 by repeated squaring
    function automatic logic [31:0] log_entry(input int i);
        logic [63:0] y;
        logic [63:0] r;
        y = (64'd1 << 30) + (64'(i) << FRAC_SH);
        r = 64'd0;
        if (i >= TAB_N) begin
            r = 64'd1 << 30;
        end else begin
            for (int k = 1; k <= 30; k++) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    r = r | (64'd1 << (30 - k));
                end
            end
        end
        return r[31:0];
    endfunction

    // 2^(i/N) in Q30 from a truncated series of e^z
    function automatic logic [31:0] exp_entry(input int i);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        z    = (64'(i) * 64'(LN2_Q30)) >> TAB_BITS;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * z) >> 30) / 64'(k);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

### rtl/hrtm_lut.sv
// ----------------------------------------------------------------------------
// hrtm_lut
// Interpolating table lookup on a Q30 fraction: registered ROM read of two
// neighbors, slope multiply, add.
// ----------------------------------------------------------------------------
module hrtm_lut (
    input  logic                 i_clk,
    input  hrtm_pkg::t_tab       i_tab,
    input  logic [29:0]          i_frac,
    output logic [31:0]          o_value
);

    localparam int PW = 32 + hrtm_pkg::FRAC_SH;

    logic [31:0] w_log [hrtm_pkg::TAB_N + 1];
    logic [31:0] w_exp [hrtm_pkg::TAB_N + 1];

    for (genvar gi = 0; gi <= hrtm_pkg::TAB_N; gi++) begin : g_rom
        localparam logic [31:0] LOG_V = hrtm_pkg::log_entry(gi);
        localparam logic [31:0] EXP_V = hrtm_pkg::exp_entry(gi);
        assign w_log[gi] = LOG_V;
        assign w_exp[gi] = EXP_V;
    end

    logic [hrtm_pkg::TAB_BITS:0]    w_ia_lo;
    logic [hrtm_pkg::TAB_BITS:0]    w_ia_hi;
    logic [31:0]                    r_lo;
    logic [31:0]                    r_hi;
    logic [hrtm_pkg::FRAC_SH-1:0]   r_rem;
    logic [31:0]                    w_diff;
    logic [PW-1:0]                  w_prod;
    logic [31:0]                    r_base;
    logic [31:0]                    r_step;
    logic [31:0]                    r_value;

    assign w_ia_lo = {1'b0, i_frac[29:hrtm_pkg::FRAC_SH]};
    assign w_ia_hi = w_ia_lo + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_tab == hrtm_pkg::TAB_EXP) begin
            r_lo <= w_exp[w_ia_lo];
            r_hi <= w_exp[w_ia_hi];
        end else begin
            r_lo <= w_log[w_ia_lo];
            r_hi <= w_log[w_ia_hi];
        end
        r_rem <= i_frac[hrtm_pkg::FRAC_SH-1:0];
    end

    // negative slope never occurs in practice; clamp it to flat
    assign w_diff = (r_hi >= r_lo) ? (r_hi - r_lo) : 32'd0;
    assign w_prod = PW'(w_diff) * PW'(r_rem);

    always_ff @(posedge i_clk) begin
        r_base  <= r_lo;
        r_step  <= w_prod[PW-1:hrtm_pkg::FRAC_SH];
        r_value <= r_base + r_step;
    end

    assign o_value = r_value;

endmodule

### rtl/hrtm_colour.sv
// ----------------------------------------------------------------------------
// hrtm_colour
// One colour channel: half-float log2, exposure gain, logarithmic knee,
// gamma and scale to 8 bits, all in Q30 fixed point. Fully pipelined.
// ----------------------------------------------------------------------------
module hrtm_colour (
    input  logic                i_clk,
    input  logic [15:0]         i_bits,
    input  logic signed [39:0]  i_gain,
    output logic [7:0]          o_value
);

    localparam int L     = hrtm_pkg::LUT_LAT;
    localparam int S_T   = 2 + L;
    localparam int S_D   = S_T + L + 1;
    localparam int S_U   = S_D + 1;
    localparam int S_N1  = S_U + 1;
    localparam int S_LU  = S_N1 + L + 1;
    localparam int S_N2  = S_LU + 5;
    localparam int S_L   = S_N2 + L + 1;
    localparam int S_WP  = S_L + 1;
    localparam int S_W   = S_WP + 1;
    localparam int S_R   = S_W + L + 1;

    // leading one among bits 33..30, then the 30 bits below it
    function automatic logic [31:0] norm_q30(input logic [33:0] v);
        logic [1:0] ip;
        ip = 2'd0;
        if (v[33]) begin
            ip = 2'd3;
        end else if (v[32]) begin
            ip = 2'd2;
        end else if (v[31]) begin
            ip = 2'd1;
        end
        return {ip, 30'(v >> ip)};
    endfunction

    // ---------------- decode ----------------
    logic              w_sgn;
    logic [4:0]        w_ex;
    logic [9:0]        w_man;
    logic [10:0]       w_v;
    logic [3:0]        w_p;
    logic signed [5:0] w_sh;
    logic signed [5:0] w_e;
    logic [40:0]       w_norm;
    hrtm_pkg::t_kind   w_kind;

    assign w_sgn  = i_bits[15];
    assign w_ex   = i_bits[14:10];
    assign w_man  = i_bits[9:0];
    assign w_v    = (w_ex == 5'd0) ? {1'b0, w_man} : {1'b1, w_man};
    assign w_sh   = (w_ex == 5'd0) ? -6'sd24 : ($signed({1'b0, w_ex}) - 6'sd25);
    assign w_e    = $signed({2'b00, w_p}) + w_sh;
    assign w_norm = {w_v, 30'd0} >> w_p;

    always_comb begin
        w_p = 4'd0;
        for (int b = 0; b < 11; b++) begin
            if (w_v[b]) begin
                w_p = 4'(b);
            end
        end
    end

    always_comb begin
        if (w_ex == 5'd31) begin
            w_kind = (w_man != 10'd0 || w_sgn) ? hrtm_pkg::KIND_ZERO : hrtm_pkg::KIND_FULL;
        end else if (w_sgn || w_v == 11'd0) begin
            w_kind = hrtm_pkg::KIND_ZERO;
        end else begin
            w_kind = hrtm_pkg::KIND_CALC;
        end
    end

    hrtm_pkg::t_kind   r_kind [1:S_R];
    logic signed [5:0] r_e    [1:S_T-1];
    logic [29:0]       r_f1;
    logic [31:0]       w_lg1;

    hrtm_lut u_log_in (
        .i_clk   (i_clk),
        .i_tab   (hrtm_pkg::TAB_LOG),
        .i_frac  (r_f1),
        .o_value (w_lg1)
    );

    // ---------------- gain ----------------
    logic signed [39:0] w_t;
    logic signed [39:0] r_t [S_T:S_L-1];
    logic [31:0]        w_mant1;

    assign w_t = $signed({8'd0, w_lg1})
               + $signed({{4{r_e[S_T-1][5]}}, r_e[S_T-1], 30'd0})
               + i_gain;

    hrtm_lut u_exp_knee (
        .i_clk   (i_clk),
        .i_tab   (hrtm_pkg::TAB_EXP),
        .i_frac  (r_t[S_T][29:0]),
        .o_value (w_mant1)
    );

    // ---------------- knee ----------------
    logic [35:0] w_x;
    logic [35:0] r_d;
    logic [63:0] w_ku;
    logic [33:0] r_u;
    logic [31:0] w_nu;
    logic [29:0] r_f2;
    logic [1:0]  r_ip1 [S_N1:S_LU-1];
    logic [31:0] w_lg2;
    logic [31:0] r_lu;
    logic [52:0] r_ph;
    logic [52:0] r_pl;
    logic [61:0] r_p  [S_LU+1:S_LU+3];
    logic [33:0] r_q0;
    logic [33:0] r_q0b;
    logic [61:0] r_qk;
    logic [61:0] w_rem;
    logic [74:0] w_qsum;
    logic [33:0] r_xk;
    logic [31:0] w_nx;
    logic [29:0] r_f3;
    logic [1:0]  r_ip2 [S_N2:S_L-1];
    logic [31:0] w_lg3;

    assign w_x  = {4'd0, w_mant1} << r_t[S_D-1][32:30];
    assign w_ku = 64'(r_d) * 64'(hrtm_pkg::KNEE_Q30);
    assign w_nu = norm_q30(r_u);
    assign w_nx = norm_q30(r_xk);
    assign w_qsum = (75'(r_ph) << hrtm_pkg::RECIP_SPLIT) + 75'(r_pl);
    assign w_rem  = r_p[S_LU+3] - r_qk;

    hrtm_lut u_log_knee (
        .i_clk   (i_clk),
        .i_tab   (hrtm_pkg::TAB_LOG),
        .i_frac  (r_f2),
        .o_value (w_lg2)
    );

    hrtm_lut u_log_back (
        .i_clk   (i_clk),
        .i_tab   (hrtm_pkg::TAB_LOG),
        .i_frac  (r_f3),
        .o_value (w_lg3)
    );

    // ---------------- gamma and scale ----------------
    logic [31:0]        w_lx;
    logic signed [39:0] r_l;
    logic signed [39:0] w_labs;
    logic [63:0]        w_wp;
    logic [33:0]        r_wmag;
    logic               r_wneg;
    logic signed [35:0] w_w;
    logic [29:0]        r_wf;
    logic signed [5:0]  r_n [S_W:S_R-1];
    logic [31:0]        w_mant2;
    logic [5:0]         w_nneg;
    logic [32:0]        r_r;
    logic [55:0]        w_y;
    logic [9:0]         w_yi;
    logic [7:0]         r_out;

    assign w_lx   = {r_ip2[S_L-1], 30'd0} + w_lg3;
    assign w_labs = r_l[39] ? -r_l : r_l;
    assign w_wp   = 64'(w_labs[34:0]) * 64'(hrtm_pkg::EXPO_Q30);
    assign w_w    = r_wneg ? -$signed({2'b00, r_wmag}) : $signed({2'b00, r_wmag});
    assign w_nneg = 6'(-r_n[S_R-1]);
    assign w_y    = 56'(r_r) * 56'(hrtm_pkg::SCALE_Q16);
    assign w_yi   = w_y[55:46];

    hrtm_lut u_exp_out (
        .i_clk   (i_clk),
        .i_tab   (hrtm_pkg::TAB_EXP),
        .i_frac  (r_wf),
        .o_value (w_mant2)
    );

    always_ff @(posedge i_clk) begin
        // class of each item travels with it
        r_kind[1] <= w_kind;
        for (int s = 2; s <= S_R; s++) begin
            if (s != S_T && s != S_WP) begin
                r_kind[s] <= r_kind[s-1];
            end
        end
        r_kind[S_T] <= (r_kind[S_T-1] == hrtm_pkg::KIND_CALC && w_t >= hrtm_pkg::SAT_LOG)
                     ? hrtm_pkg::KIND_FULL : r_kind[S_T-1];
        r_kind[S_WP] <= (r_kind[S_WP-1] == hrtm_pkg::KIND_CALC && r_l < hrtm_pkg::FLOOR_LOG)
                      ? hrtm_pkg::KIND_ZERO : r_kind[S_WP-1];

        r_e[1] <= w_e;
        for (int s = 2; s < S_T; s++) begin
            r_e[s] <= r_e[s-1];
        end
        r_f1 <= w_norm[29:0];

        r_t[S_T] <= w_t;
        for (int s = S_T + 1; s < S_L; s++) begin
            r_t[s] <= r_t[s-1];
        end

        r_d <= (w_x > 36'(hrtm_pkg::Q30_ONE)) ? (w_x - 36'(hrtm_pkg::Q30_ONE)) : 36'd0;
        r_u <= hrtm_pkg::Q30_ONE + w_ku[63:30];

        r_f2      <= w_nu[29:0];
        r_ip1[S_N1] <= w_nu[31:30];
        for (int s = S_N1 + 1; s < S_LU; s++) begin
            r_ip1[s] <= r_ip1[s-1];
        end
        r_lu <= {r_ip1[S_LU-1], 30'd0} + w_lg2;

        // divide by the knee: reciprocal estimate, then one correction
        r_ph <= 53'(r_lu) * 53'(hrtm_pkg::RECIP_HI);
        r_pl <= 53'(r_lu) * 53'(hrtm_pkg::RECIP_LO);
        r_p[S_LU+1] <= 62'(r_lu) * 62'(hrtm_pkg::LN2_Q30);
        r_q0 <= w_qsum[hrtm_pkg::RECIP_SH +: 34];
        r_p[S_LU+2] <= r_p[S_LU+1];
        r_qk  <= 62'(r_q0) * 62'(hrtm_pkg::KNEE_Q30);
        r_q0b <= r_q0;
        r_p[S_LU+3] <= r_p[S_LU+2];
        r_xk <= hrtm_pkg::Q30_ONE
              + ((w_rem >= 62'(hrtm_pkg::KNEE_Q30)) ? (r_q0b + 34'd1) : r_q0b);

        r_f3        <= w_nx[29:0];
        r_ip2[S_N2] <= w_nx[31:30];
        for (int s = S_N2 + 1; s < S_L; s++) begin
            r_ip2[s] <= r_ip2[s-1];
        end

        // below or at unity the knee is bypassed
        r_l <= (r_t[S_L-1] <= 40'sd0) ? r_t[S_L-1] : $signed({8'd0, w_lx});

        r_wmag <= w_wp[63:30];
        r_wneg <= r_l[39];

        r_wf     <= w_w[29:0];
        r_n[S_W] <= w_w[35:30];
        for (int s = S_W + 1; s < S_R; s++) begin
            r_n[s] <= r_n[s-1];
        end

        r_r <= r_n[S_R-1][5] ? (33'(w_mant2) >> w_nneg) : (33'(w_mant2) << r_n[S_R-1]);

        case (r_kind[S_R])
            hrtm_pkg::KIND_ZERO: r_out <= 8'd0;
            hrtm_pkg::KIND_FULL: r_out <= 8'd255;
            default:             r_out <= (w_yi > 10'd255) ? 8'd255 : w_yi[7:0];
        endcase
    end

    assign o_value = r_out;

endmodule

### rtl/hrtm_alpha.sv
// ----------------------------------------------------------------------------
// hrtm_alpha
// Alpha channel: half-float times 255, rounded and clamped, then delayed to
// line up with the colour pipeline.
// ----------------------------------------------------------------------------
module hrtm_alpha (
    input  logic        i_clk,
    input  logic [15:0] i_bits,
    output logic [7:0]  o_value
);

    localparam int LAT = hrtm_pkg::PIPE_LAT;

    logic        w_sgn;
    logic [4:0]  w_ex;
    logic [9:0]  w_man;
    logic [18:0] w_num;
    logic [4:0]  w_sh;
    logic [24:0] w_rnd;
    logic [7:0]  w_val;
    logic [7:0]  r_a [1:LAT];

    assign w_sgn = i_bits[15];
    assign w_ex  = i_bits[14:10];
    assign w_man = i_bits[9:0];
    assign w_num = 19'((w_ex == 5'd0) ? {1'b0, w_man} : {1'b1, w_man}) * 19'd255;
    assign w_sh  = (w_ex == 5'd0) ? 5'd24 : (5'd25 - w_ex);
    assign w_rnd = (25'(w_num) + (25'd1 << (w_sh - 5'd1))) >> w_sh;

    always_comb begin
        if (w_ex == 5'd31) begin
            w_val = (w_man != 10'd0 || w_sgn) ? 8'd0 : 8'd255;
        end else if (w_sgn) begin
            w_val = 8'd0;
        end else if (w_ex >= 5'd15) begin
            w_val = 8'd255;
        end else begin
            w_val = (w_rnd > 25'd255) ? 8'd255 : w_rnd[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[1] <= w_val;
        for (int s = 2; s <= LAT; s++) begin
            r_a[s] <= r_a[s-1];
        end
    end

    assign o_value = r_a[LAT];

endmodule

### rtl/half_rgba_tone_map_to_8bit_unit.sv
// ----------------------------------------------------------------------------
// half_rgba_tone_map_to_8bit_unit
// Half-float RGBA pixel to 8-bit RGBA with exposure, knee and gamma.
//
//   channel   signals                                  direction
//   config    i_cfg_valid/o_cfg_ready, exposure_q8     in, one register
//   pixel     start/busy, red/green/blue/alpha_in      in, 4 x 16 bit half
//   result    o_done, red/green/blue/alpha_out         out, 4 x 8 bit
//
// One pixel per clock; each result appears once its start has passed through
// five table lookups and sixteen arithmetic stages in the colour path.
// busy stays low: the pipeline never stops and results are not held back.
// Synchronous active-low reset clears the valid line and the exposure register.
// ----------------------------------------------------------------------------
module half_rgba_tone_map_to_8bit_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_exposure_q8,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_red_in,
    input  logic [15:0] i_green_in,
    input  logic [15:0] i_blue_in,
    input  logic [15:0] i_alpha_in,
    output logic        o_done,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_alpha_out
);

    localparam int LAT = hrtm_pkg::PIPE_LAT;

    logic [13:0]        r_exposure;
    logic signed [39:0] w_graw;
    logic signed [39:0] r_gain;
    logic [LAT-1:0]     r_vld;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure <= 14'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_exposure <= i_cfg_exposure_q8;
        end
    end

    // gain exponent in Q30, saturated to plus or minus twenty stops
    assign w_graw = ($signed({{26{r_exposure[13]}}, r_exposure}) <<< 22) + hrtm_pkg::OFFSET_Q30;

    always_ff @(posedge i_clk) begin
        if (w_graw > hrtm_pkg::GAIN_LIM) begin
            r_gain <= hrtm_pkg::GAIN_LIM;
        end else if (w_graw < -hrtm_pkg::GAIN_LIM) begin
            r_gain <= -hrtm_pkg::GAIN_LIM;
        end else begin
            r_gain <= w_graw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start && !busy};
        end
    end

    assign o_done = r_vld[LAT-1];

    hrtm_colour u_red (
        .i_clk   (i_clk),
        .i_bits  (i_red_in),
        .i_gain  (r_gain),
        .o_value (o_red_out)
    );

    hrtm_colour u_green (
        .i_clk   (i_clk),
        .i_bits  (i_green_in),
        .i_gain  (r_gain),
        .o_value (o_green_out)
    );

    hrtm_colour u_blue (
        .i_clk   (i_clk),
        .i_bits  (i_blue_in),
        .i_gain  (r_gain),
        .o_value (o_blue_out)
    );

    hrtm_alpha u_alpha (
        .i_clk   (i_clk),
        .i_bits  (i_alpha_in),
        .o_value (o_alpha_out)
    );

`ifndef SYNTHESIS
    a_item_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_done)
        else $error("accepted item did not come out after the pipeline latency");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> r_exposure == $past(i_cfg_exposure_q8))
        else $error("exposure register did not take the written value");

    a_negative_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_red_in[15] |-> ##LAT o_red_out == 8'd0)
        else $error("negative red input gave a nonzero result");

    a_alpha_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_alpha_in == 16'h7C00 |-> ##LAT o_alpha_out == 8'd255)
        else $error("infinite alpha did not saturate");
`endif

endmodule
